@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FLA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLA_ASSERT(lbl, clk, rst, prop, msg)
`define FLA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/fla_pkg.sv @@
// ----------------------------------------------------------------------------
// fla_pkg
// Types, codes and widths shared by the free list allocator modules.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int ADDR_BITS      = 21;
  localparam int LEN_W          = 22;
  localparam int SUM_W          = 23;
  localparam int MAX_BLOCKS_DEF = 128;
  localparam int DEFAULT_ALIGN  = 32;

  localparam logic [SUM_W-1:0] ADDR_SPACE = SUM_W'(1) << ADDR_BITS;

  localparam logic [1:0] FN_INIT  = 2'd0;
  localparam logic [1:0] FN_ALLOC = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_REGION_TOP  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK, ST_ZERO, ST_NOFIT, ST_FULL, ST_RANGE, ST_OVERLAP
  } status_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_INIT, DP_RD_IDX, DP_ALIGN, DP_NEXT, DP_HIT,
    DP_A_REMOVE, DP_A_REMAIN, DP_A_PAD, DP_A_GAP, DP_A_W2,
    DP_SH_RDN, DP_SH_WDN, DP_SH_ENDDN, DP_SH_RUP, DP_SH_WUP, DP_SH_ENDUP,
    DP_PREV, DP_F_BOTH, DP_F_PREV, DP_F_NEXT, DP_F_GAP, DP_F_NEW, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic size_zero;
    logic range_bad;
    logic idx_lt;
    logic fit;
    logic pz;
    logic rz;
    logic full;
    logic below;
    logic ovl;
    logic mp;
    logic mn;
    logic dn_more;
    logic up_more;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/fla_if.sv @@
// ----------------------------------------------------------------------------
// fla_req_if / fla_rsp_if
// Request and result channels of the free list allocator.
// ----------------------------------------------------------------------------
interface fla_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [20:0] req_addr;
  logic [21:0] req_size;
  logic [21:0] req_align;
  modport source(output valid, func, req_addr, req_size, req_align, input ready);
  modport sink(input valid, func, req_addr, req_size, req_align, output ready);
endinterface

interface fla_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [20:0] alloc_addr;
  logic [21:0] high_water;
  modport source(output valid, status, alloc_addr, high_water, input ready);
  modport sink(input valid, status, alloc_addr, high_water, output ready);
endinterface

@@ sv/free_list_region_allocator.sv @@
// ----------------------------------------------------------------------------
// free_list_region_allocator
// First-fit free list allocator with alignment and coalescing of freed blocks.
// ----------------------------------------------------------------------------
// Requests arrive on req (func, req_addr, req_size, req_align) and each one
// gives exactly one result on rsp (status, alloc_addr, high_water). Both are
// valid/ready channels; a request is taken when valid and ready are high.
// region_base and region_top are written through cfg_we/cfg_index/cfg_data.
// The user must write them only while no request is in flight; the block
// does not enforce it. They act on the next init or free. One request is
// worked on at a time. An alloc reads the sorted list one entry at a time
// until a block fits, then moves the entries behind it when a block is
// removed or split. A free scans the entries below the freed address and
// may move the entries above it. The result register frees the request
// side: the next request is taken while an earlier result still waits; a
// stalled receiver holds a finished request back only when that next result
// is ready to leave. After reset the list is built for the reset register
// values while req.ready stays low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module free_list_region_allocator #(
  parameter int MAX_BLOCKS = fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fla_req_if.sink      req,
  fla_rsp_if.source    rsp,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [21:0]  cfg_data
);

  fla_pkg::dp_cmd_t  cmd;
  fla_pkg::dp_stat_t st;

  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  fla_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (req.func),
    .req_addr   (req.req_addr),
    .req_size   (req.req_size),
    .req_align  (req.req_align),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .status     (rsp.status),
    .alloc_addr (rsp.alloc_addr),
    .high_water (rsp.high_water)
  );

  // Only one request is in flight at a time.
  `FLA_ASSERT(a_one_request, clk, rst, (req.valid && req.ready) |=> !req.ready, "busy")
  // A failed request never reports an address.
  `FLA_ASSERT(a_addr_zero, clk, rst, (rsp.valid && rsp.status != fla_pkg::ST_OK) |-> (rsp.alloc_addr == '0), "addr")
  // A new result appears only at the end of a request, never out of idle.
  `FLA_ASSERT(a_result_source, clk, rst, $rose(rsp.valid) |-> !$past(req.ready), "source")

endmodule

@@ sv/fla_ctrl.sv @@
// ----------------------------------------------------------------------------
// fla_ctrl
// Sequencer that steps the datapath through init, alloc and free requests.
// ----------------------------------------------------------------------------
module fla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fla_pkg::dp_stat_t  st,
  output fla_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_DISP, S_A_RD, S_A_AL, S_A_CK, S_A_DEC, S_A_W1, S_A_W2,
    S_F_RD, S_F_CMP, S_F_CHK, S_F_NEW, S_SHD, S_SHD_W, S_SHU, S_SHU_W, S_DONE
  } state_t;

  state_t            state, state_next;
  state_t            ret, ret_next;
  fla_pkg::status_t  code, code_next;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    code_next  = code;
    cmd.op     = fla_pkg::DP_NOP;
    cmd.code   = code;
    in_ready   = 1'b0;
    case (state)
      S_BOOT: begin
        cmd.op     = fla_pkg::DP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = fla_pkg::DP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_DONE;
        case (st.func)
          fla_pkg::FN_INIT: begin
            cmd.op    = fla_pkg::DP_INIT;
            code_next = fla_pkg::ST_OK;
          end
          fla_pkg::FN_ALLOC: begin
            if (st.size_zero) code_next = fla_pkg::ST_ZERO;
            else state_next = S_A_RD;
          end
          fla_pkg::FN_FREE: begin
            if (st.size_zero) code_next = fla_pkg::ST_ZERO;
            else if (st.range_bad) code_next = fla_pkg::ST_RANGE;
            else state_next = S_F_RD;
          end
          default: code_next = fla_pkg::ST_RANGE;
        endcase
      end
      S_A_RD: begin
        if (st.idx_lt) begin
          cmd.op     = fla_pkg::DP_RD_IDX;
          state_next = S_A_AL;
        end else begin
          code_next  = fla_pkg::ST_NOFIT;
          state_next = S_DONE;
        end
      end
      S_A_AL: begin
        cmd.op     = fla_pkg::DP_ALIGN;
        state_next = S_A_CK;
      end
      S_A_CK: begin
        if (st.fit) begin
          cmd.op     = fla_pkg::DP_HIT;
          state_next = S_A_DEC;
        end else begin
          cmd.op     = fla_pkg::DP_NEXT;
          state_next = S_A_RD;
        end
      end
      S_A_DEC: begin
        code_next = fla_pkg::ST_OK;
        if (st.pz && st.rz) begin
          cmd.op     = fla_pkg::DP_A_REMOVE;
          ret_next   = S_DONE;
          state_next = S_SHD;
        end else if (st.pz) begin
          cmd.op     = fla_pkg::DP_A_REMAIN;
          state_next = S_DONE;
        end else if (st.rz) begin
          cmd.op     = fla_pkg::DP_A_PAD;
          state_next = S_DONE;
        end else if (st.full) begin
          code_next  = fla_pkg::ST_FULL;
          state_next = S_DONE;
        end else begin
          // The block splits in two: open a slot behind it first.
          cmd.op     = fla_pkg::DP_A_GAP;
          ret_next   = S_A_W1;
          state_next = S_SHU;
        end
      end
      S_A_W1: begin
        cmd.op     = fla_pkg::DP_A_PAD;
        state_next = S_A_W2;
      end
      S_A_W2: begin
        cmd.op     = fla_pkg::DP_A_W2;
        state_next = S_DONE;
      end
      S_F_RD: begin
        if (st.idx_lt) begin
          cmd.op     = fla_pkg::DP_RD_IDX;
          state_next = S_F_CMP;
        end else begin
          state_next = S_F_CHK;
        end
      end
      S_F_CMP: begin
        if (st.below) begin
          cmd.op     = fla_pkg::DP_PREV;
          state_next = S_F_RD;
        end else begin
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        code_next  = fla_pkg::ST_OK;
        state_next = S_DONE;
        if (st.ovl) begin
          code_next = fla_pkg::ST_OVERLAP;
        end else if (st.full) begin
          code_next = fla_pkg::ST_FULL;
        end else if (st.mp && st.mn) begin
          cmd.op     = fla_pkg::DP_F_BOTH;
          ret_next   = S_DONE;
          state_next = S_SHD;
        end else if (st.mp) begin
          cmd.op = fla_pkg::DP_F_PREV;
        end else if (st.mn) begin
          cmd.op = fla_pkg::DP_F_NEXT;
        end else begin
          cmd.op     = fla_pkg::DP_F_GAP;
          ret_next   = S_F_NEW;
          state_next = S_SHU;
        end
      end
      S_F_NEW: begin
        cmd.op     = fla_pkg::DP_F_NEW;
        state_next = S_DONE;
      end
      S_SHD: begin
        if (st.dn_more) begin
          cmd.op     = fla_pkg::DP_SH_RDN;
          state_next = S_SHD_W;
        end else begin
          cmd.op     = fla_pkg::DP_SH_ENDDN;
          state_next = ret;
        end
      end
      S_SHD_W: begin
        cmd.op     = fla_pkg::DP_SH_WDN;
        state_next = S_SHD;
      end
      S_SHU: begin
        if (st.up_more) begin
          cmd.op     = fla_pkg::DP_SH_RUP;
          state_next = S_SHU_W;
        end else begin
          cmd.op     = fla_pkg::DP_SH_ENDUP;
          state_next = ret;
        end
      end
      S_SHU_W: begin
        cmd.op     = fla_pkg::DP_SH_WUP;
        state_next = S_SHU;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op     = fla_pkg::DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
      ret   <= S_DONE;
      code  <= fla_pkg::ST_OK;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      code  <= code_next;
    end
  end

endmodule

@@ sv/fla_dp.sv @@
// ----------------------------------------------------------------------------
// fla_dp
// Free list memory, scan and shift pointers, arithmetic and result register.
// ----------------------------------------------------------------------------
module fla_dp #(
  parameter int MAX_BLOCKS = fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [21:0]       cfg_data,
  input  logic [1:0]        func,
  input  logic [20:0]       req_addr,
  input  logic [21:0]       req_size,
  input  logic [21:0]       req_align,
  input  fla_pkg::dp_cmd_t  cmd,
  output fla_pkg::dp_stat_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [20:0]       alloc_addr,
  output logic [21:0]       high_water
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = fla_pkg::ADDR_BITS;
  localparam int LW    = fla_pkg::LEN_W;
  localparam int SW    = fla_pkg::SUM_W;

  logic [AW-1:0]    mem_start [MAX_BLOCKS];
  logic [LW-1:0]    mem_len   [MAX_BLOCKS];

  logic [AW-1:0]    base_r;
  logic [LW-1:0]    top_r;
  logic [CNT_W-1:0] count, idx, j, gap_pos;
  logic [1:0]       func_r;
  logic [AW-1:0]    addr_r;
  logic [LW-1:0]    size_r, am1;
  logic [AW-1:0]    rd_start, hit_start, prev_start, res_addr;
  logic [LW-1:0]    rd_len, prev_len, hw;
  logic [SW-1:0]    cand, blk_end, end_r;
  logic             pz_r, rz_r;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_a, wr_a;
  logic [AW-1:0]    wr_s;
  logic [LW-1:0]    wr_l;

  logic [SW-1:0]    eff_top, below_end, rq_end, cand_sum;
  logic [SW:0]      end_c;
  logic [LW-1:0]    am1_in;
  logic             have_prev;

  always_comb begin
    am1_in = LW'(fla_pkg::DEFAULT_ALIGN - 1);
    for (int k = 0; k < LW; k++) begin
      if (req_align[k]) am1_in = (LW'(1) << k) - LW'(1);
    end
  end

  assign eff_top   = ({1'b0, top_r} > fla_pkg::ADDR_SPACE) ? fla_pkg::ADDR_SPACE
                                                            : {1'b0, top_r};
  assign below_end = {2'b0, prev_start} + {1'b0, prev_len};
  assign rq_end    = {2'b0, addr_r} + {1'b0, size_r};
  assign cand_sum  = {2'b0, rd_start} + {1'b0, am1};
  assign end_c     = {1'b0, cand} + {2'b0, size_r};
  assign have_prev = (idx != '0);

  always_comb begin
    st.func      = func_r;
    st.size_zero = (size_r == '0);
    st.range_bad = (addr_r < base_r) || (rq_end > eff_top);
    st.idx_lt    = (idx < count);
    st.fit       = (end_c <= {1'b0, blk_end});
    st.pz        = pz_r;
    st.rz        = rz_r;
    st.full      = (count >= CNT_W'(MAX_BLOCKS));
    st.below     = (rd_start < addr_r);
    st.ovl       = (have_prev && (below_end > {2'b0, addr_r}))
                || ((idx < count) && (rq_end > {2'b0, rd_start}));
    st.mp        = have_prev && (below_end == {2'b0, addr_r});
    st.mn        = (idx < count) && (rq_end == {2'b0, rd_start});
    st.dn_more   = ((j + CNT_W'(1)) < count);
    st.up_more   = (j > gap_pos);
    st.out_free  = !out_valid || out_ready;
  end

  // Memory port controls for each datapath step.
  always_comb begin
    rd_en = 1'b0;
    rd_a  = idx[IDX_W-1:0];
    wr_en = 1'b0;
    wr_a  = idx[IDX_W-1:0];
    wr_s  = rd_start;
    wr_l  = rd_len;
    case (cmd.op)
      fla_pkg::DP_INIT: begin
        wr_en = 1'b1;
        wr_a  = '0;
        wr_s  = base_r;
        wr_l  = LW'(eff_top - {2'b0, base_r});
      end
      fla_pkg::DP_RD_IDX: rd_en = 1'b1;
      fla_pkg::DP_A_REMAIN: begin
        wr_en = 1'b1;
        wr_s  = end_r[AW-1:0];
        wr_l  = LW'(blk_end - end_r);
      end
      fla_pkg::DP_A_PAD: begin
        wr_en = 1'b1;
        wr_s  = hit_start;
        wr_l  = LW'(cand - {2'b0, hit_start});
      end
      fla_pkg::DP_A_W2: begin
        wr_en = 1'b1;
        wr_a  = IDX_W'(idx + CNT_W'(1));
        wr_s  = end_r[AW-1:0];
        wr_l  = LW'(blk_end - end_r);
      end
      fla_pkg::DP_SH_RDN: begin
        rd_en = 1'b1;
        rd_a  = IDX_W'(j + CNT_W'(1));
      end
      fla_pkg::DP_SH_WDN, fla_pkg::DP_SH_WUP: begin
        wr_en = 1'b1;
        wr_a  = j[IDX_W-1:0];
      end
      fla_pkg::DP_SH_RUP: begin
        rd_en = 1'b1;
        rd_a  = IDX_W'(j - CNT_W'(1));
      end
      fla_pkg::DP_F_BOTH: begin
        wr_en = 1'b1;
        wr_a  = IDX_W'(idx - CNT_W'(1));
        wr_s  = prev_start;
        wr_l  = prev_len + size_r + rd_len;
      end
      fla_pkg::DP_F_PREV: begin
        wr_en = 1'b1;
        wr_a  = IDX_W'(idx - CNT_W'(1));
        wr_s  = prev_start;
        wr_l  = prev_len + size_r;
      end
      fla_pkg::DP_F_NEXT: begin
        wr_en = 1'b1;
        wr_s  = addr_r;
        wr_l  = size_r + rd_len;
      end
      fla_pkg::DP_F_NEW: begin
        wr_en = 1'b1;
        wr_s  = addr_r;
        wr_l  = size_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_a] <= wr_s;
      mem_len[wr_a]   <= wr_l;
    end
    if (rd_en) begin
      rd_start <= mem_start[rd_a];
      rd_len   <= mem_len[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r    <= '0;
      top_r     <= LW'(fla_pkg::ADDR_SPACE);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == fla_pkg::CFG_REGION_BASE) base_r <= cfg_data[AW-1:0];
        else top_r <= cfg_data;
      end
      if (cmd.op == fla_pkg::DP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        fla_pkg::DP_INIT:     count <= ({2'b0, base_r} < eff_top) ? CNT_W'(1) : '0;
        fla_pkg::DP_SH_ENDDN: count <= count - CNT_W'(1);
        fla_pkg::DP_SH_ENDUP: count <= count + CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fla_pkg::DP_LOAD: begin
        func_r   <= func;
        addr_r   <= req_addr;
        size_r   <= req_size;
        am1      <= am1_in;
        idx      <= '0;
        res_addr <= '0;
      end
      fla_pkg::DP_INIT: hw <= {1'b0, base_r};
      fla_pkg::DP_ALIGN: begin
        cand    <= cand_sum & ~{1'b0, am1};
        blk_end <= {2'b0, rd_start} + {1'b0, rd_len};
      end
      fla_pkg::DP_NEXT: idx <= idx + CNT_W'(1);
      fla_pkg::DP_HIT: begin
        end_r     <= end_c[SW-1:0];
        hit_start <= rd_start;
        pz_r      <= (cand == {2'b0, rd_start});
        rz_r      <= (end_c == {1'b0, blk_end});
      end
      fla_pkg::DP_A_REMOVE, fla_pkg::DP_A_REMAIN, fla_pkg::DP_A_PAD,
      fla_pkg::DP_A_GAP: begin
        res_addr <= cand[AW-1:0];
        if (end_r > {1'b0, hw}) hw <= end_r[LW-1:0];
        if (cmd.op == fla_pkg::DP_A_REMOVE) j <= idx;
        if (cmd.op == fla_pkg::DP_A_GAP) begin
          j       <= count;
          gap_pos <= idx + CNT_W'(1);
        end
      end
      fla_pkg::DP_SH_WDN: j <= j + CNT_W'(1);
      fla_pkg::DP_SH_WUP: j <= j - CNT_W'(1);
      fla_pkg::DP_PREV: begin
        prev_start <= rd_start;
        prev_len   <= rd_len;
        idx        <= idx + CNT_W'(1);
      end
      fla_pkg::DP_F_BOTH: j <= idx;
      fla_pkg::DP_F_GAP: begin
        j       <= count;
        gap_pos <= idx;
      end
      fla_pkg::DP_EMIT: begin
        status     <= cmd.code;
        alloc_addr <= res_addr;
        high_water <= hw;
      end
      default: begin
      end
    endcase
  end

endmodule
